// ===== design/hfa_pkg.sv =====
// Package for the first-fit heap allocator: arena constants, header word,
// channel structs, sequencer enums and address helpers. No dependencies.
package hfa_pkg;

   localparam int ARENA_BYTES  = 64 * 1024;
   localparam int HEADER_BYTES = 24;
   localparam int ALIGN_BYTES  = 8;
   localparam int MIN_PAYLOAD  = 8;

   localparam int SLOTS    = ARENA_BYTES / ALIGN_BYTES;
   localparam int SLOT_W   = $clog2(SLOTS);
   localparam int LINK_W   = SLOT_W + 1;
   localparam int ALIGN_SH = $clog2(ALIGN_BYTES);
   localparam int SIZE_W   = 16;
   localparam int ADDR_W   = 16;
   localparam int NEED_W   = SIZE_W + 1;

   localparam logic [LINK_W-1:0] NIL_LINK  = LINK_W'(SLOTS);
   localparam logic [SIZE_W-1:0] INIT_SIZE = SIZE_W'(ARENA_BYTES - 2 * HEADER_BYTES);

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_BAD_SIZE = 2'd1;
   localparam logic [1:0] STAT_NO_FIT   = 2'd2;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   typedef struct packed {
      logic              mode;
      logic [SIZE_W-1:0] request_bytes;
      logic [ADDR_W-1:0] block_address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic [1:0]        status;
   } rsp_type;

   typedef struct packed {
      logic [SIZE_W-1:0] size;
      logic              free;
      logic [SIZE_W-1:0] psize;
      logic              pfree;
      logic [LINK_W-1:0] nxt;
      logic [LINK_W-1:0] prv;
   } hdr_word_type;

   typedef struct packed {
      logic              we;
      logic [SLOT_W-1:0] waddr;
      hdr_word_type      wdata;
      logic              re;
      logic [SLOT_W-1:0] raddr;
   } mem_req_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INIT0,
      S_INIT1,
      S_RD,
      S_WR
   } state_type;

   typedef enum logic [4:0] {
      OP_WALK,
      OP_UL_HEAD,
      OP_UL_P,
      OP_UL_N,
      OP_UL_SELF,
      OP_A_SIZE,
      OP_A_GOT,
      OP_A_FREE,
      OP_A_TAIL,
      OP_PUSH,
      OP_PUSH_HD,
      OP_F_HDR,
      OP_F_RDB,
      OP_F_SIZE,
      OP_F_RDA,
      OP_F_ADD,
      OP_F_FREE,
      OP_F_TAIL
   } op_type;

   typedef enum logic [1:0] {
      C_ALLOC,
      C_FREE_B,
      C_FREE_A
   } cont_type;

   function automatic logic [SLOT_W-1:0] slot_after(input logic [SLOT_W-1:0] slot,
                                                     input logic [SIZE_W-1:0] size);
      logic [ADDR_W-1:0] off;
      off = (ADDR_W'(slot) << ALIGN_SH) + size + ADDR_W'(HEADER_BYTES);
      return off[ADDR_W-1:ALIGN_SH];
   endfunction

   function automatic logic [SLOT_W-1:0] slot_before(input logic [SLOT_W-1:0] slot,
                                                      input logic [SIZE_W-1:0] psize);
      logic [ADDR_W-1:0] back;
      logic [ADDR_W-1:0] off;
      back = psize + ADDR_W'(HEADER_BYTES);
      off  = (ADDR_W'(slot) << ALIGN_SH) - back;
      return off[ADDR_W-1:ALIGN_SH];
   endfunction

   function automatic logic [LINK_W-1:0] link_of(input logic [LINK_W-1:0] v);
      return v[SLOT_W] ? NIL_LINK : v;
   endfunction

endpackage

// ===== design/hfa_hdr_mem.sv =====
// Header memory: one word per slot, one write and one registered read per cycle.
// Depends on hfa_pkg.
module hfa_hdr_mem import hfa_pkg::*; (
   input  logic         clock,
   input  mem_req_type  mem_req,
   output hdr_word_type rd_data
);

   hdr_word_type hdr_mem [SLOTS];
   hdr_word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         hdr_mem[mem_req.waddr] <= mem_req.wdata;
      end
      if (mem_req.re) begin
         rd_data_ff <= hdr_mem[mem_req.raddr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/hfa_ctrl.sv =====
// Allocator sequencer: free-list walk, split, coalesce and list updates as
// read-modify-write steps on the header memory. Depends on hfa_pkg.
module hfa_ctrl import hfa_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  req_type      req_data,
   output logic         busy,
   output logic         rsp_valid,
   output rsp_type      rsp_data,
   output mem_req_type  mem_req,
   input  hdr_word_type rd_data
);

   state_type          state_ff, state_in;
   op_type             op_ff, op_in;
   cont_type           cont_ff, cont_in;
   logic               ready_ff, ready_in;
   logic [LINK_W-1:0]  head_ff, head_in;
   logic               mode_ff, mode_in;
   logic [NEED_W-1:0]  need_ff, need_in;
   logic [SLOT_W-1:0]  cur_ff, cur_in;
   logic [SLOT_W-1:0]  got_ff, got_in;
   logic [SLOT_W-1:0]  blk_ff, blk_in;
   logic [SLOT_W-1:0]  a_ff, a_in;
   logic [SLOT_W-1:0]  b_ff, b_in;
   logic [SLOT_W-1:0]  pu_ff, pu_in;
   logic [SIZE_W-1:0]  ns_ff, ns_in;
   logic [SIZE_W-1:0]  asz_ff, asz_in;
   logic [SIZE_W-1:0]  sz_ff, sz_in;
   logic [SIZE_W-1:0]  cw_size_ff, cw_size_in;
   logic               cw_free_ff, cw_free_in;
   logic [SLOT_W-1:0]  ul_slot_ff, ul_slot_in;
   logic [LINK_W-1:0]  ul_nxt_ff, ul_nxt_in;
   logic [LINK_W-1:0]  ul_prv_ff, ul_prv_in;
   logic [LINK_W-1:0]  steps_ff, steps_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               accept;
   logic               finish;
   logic               walk_more;
   logic               init_needed;
   hdr_word_type       patched;
   logic [SLOT_W-1:0]  op_addr;
   logic               op_writes;

   assign busy        = (state_ff != S_IDLE);
   assign accept      = start && !busy;
   assign init_needed = (req_data.mode == MODE_ALLOC) && (req_data.request_bytes != '0)
                        && !ready_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_ff;

   function automatic op_type ul_first(input logic [SLOT_W-1:0] slot,
                                       input logic [LINK_W-1:0] nxt,
                                       input logic [LINK_W-1:0] prv,
                                       input logic [LINK_W-1:0] head);
      op_type r;
      if ({1'b0, slot} == head) begin
         r = (nxt != NIL_LINK) ? OP_UL_HEAD : OP_UL_SELF;
      end else if (prv != NIL_LINK) begin
         r = OP_UL_P;
      end else if (nxt != NIL_LINK) begin
         r = OP_UL_N;
      end else begin
         r = OP_UL_SELF;
      end
      return r;
   endfunction

   always_comb begin
      case (op_ff) inside
         OP_UL_HEAD, OP_PUSH_HD:              op_addr = head_ff[SLOT_W-1:0];
         OP_UL_P:                             op_addr = ul_prv_ff[SLOT_W-1:0];
         OP_UL_N:                             op_addr = ul_nxt_ff[SLOT_W-1:0];
         OP_UL_SELF:                          op_addr = ul_slot_ff;
         OP_WALK, OP_A_SIZE:                  op_addr = cur_ff;
         OP_A_GOT, OP_A_FREE:                 op_addr = got_ff;
         OP_A_TAIL, OP_F_RDA, OP_F_TAIL:      op_addr = a_ff;
         OP_PUSH:                             op_addr = pu_ff;
         OP_F_RDB:                            op_addr = b_ff;
         default:                             op_addr = blk_ff;
      endcase
   end

   always_comb begin
      patched   = rd_data;
      op_writes = 1'b1;
      case (op_ff)
         OP_UL_HEAD: patched.prv = NIL_LINK;
         OP_UL_P:    patched.nxt = ul_nxt_ff;
         OP_UL_N:    patched.prv = ul_prv_ff;
         OP_UL_SELF: begin
            patched.nxt = NIL_LINK;
            patched.prv = NIL_LINK;
         end
         OP_A_SIZE:  patched.size = cw_size_ff - need_ff[SIZE_W-1:0]
                                    - SIZE_W'(HEADER_BYTES);
         OP_A_GOT: begin
            patched.psize = sz_ff;
            patched.pfree = cw_free_ff;
            patched.size  = need_ff[SIZE_W-1:0];
         end
         OP_A_FREE:  patched.free = 1'b0;
         OP_A_TAIL: begin
            patched.psize = sz_ff;
            patched.pfree = 1'b0;
         end
         OP_PUSH: begin
            patched.prv = NIL_LINK;
            patched.nxt = head_ff;
         end
         OP_PUSH_HD: patched.prv = {1'b0, pu_ff};
         OP_F_SIZE:  patched.size = ns_ff;
         OP_F_ADD:   patched.size = rd_data.size + SIZE_W'(HEADER_BYTES) + asz_ff;
         OP_F_FREE:  patched.free = 1'b1;
         OP_F_TAIL: begin
            patched.psize = sz_ff;
            patched.pfree = 1'b1;
         end
         default:    op_writes = 1'b0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && !finish) begin
               state_in = init_needed ? S_INIT0 : S_RD;
            end
         end
         S_INIT0: state_in = S_INIT1;
         S_INIT1: state_in = S_RD;
         S_RD:    state_in = S_WR;
         S_WR: begin
            if (finish) begin
               state_in = S_IDLE;
            end else if (!walk_more) begin
               state_in = S_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      logic [NEED_W-1:0] need_calc;
      logic [ADDR_W-1:0] off;
      logic [LINK_W-1:0] nx;
      logic              ul_start;
      logic [SLOT_W-1:0] ul_s;
      logic [LINK_W-1:0] ul_n;
      logic [LINK_W-1:0] ul_p;
      logic              push_done;

      need_calc = ({1'b0, req_data.request_bytes} + NEED_W'(ALIGN_BYTES - 1))
                  & ~NEED_W'(ALIGN_BYTES - 1);
      if (need_calc < NEED_W'(MIN_PAYLOAD)) begin
         need_calc = NEED_W'(MIN_PAYLOAD);
      end
      off       = req_data.block_address - ADDR_W'(HEADER_BYTES);
      nx        = link_of(rd_data.nxt);
      ul_start  = 1'b0;
      ul_s      = '0;
      ul_n      = NIL_LINK;
      ul_p      = NIL_LINK;
      push_done = 1'b0;

      op_in        = op_ff;
      cont_in      = cont_ff;
      ready_in     = ready_ff;
      head_in      = head_ff;
      mode_in      = mode_ff;
      need_in      = need_ff;
      cur_in       = cur_ff;
      got_in       = got_ff;
      blk_in       = blk_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      pu_in        = pu_ff;
      ns_in        = ns_ff;
      asz_in       = asz_ff;
      sz_in        = sz_ff;
      cw_size_in   = cw_size_ff;
      cw_free_in   = cw_free_ff;
      ul_slot_in   = ul_slot_ff;
      ul_nxt_in    = ul_nxt_ff;
      ul_prv_in    = ul_prv_ff;
      steps_in     = steps_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      finish       = 1'b0;
      walk_more    = 1'b0;
      mem_req      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mode_in = req_data.mode;
               if (req_data.mode == MODE_ALLOC) begin
                  need_in = need_calc;
                  if (req_data.request_bytes == '0) begin
                     finish = 1'b1;
                     rsp_in = '{address: '0, status: STAT_BAD_SIZE};
                  end else if (ready_ff) begin
                     if (head_ff == NIL_LINK) begin
                        finish = 1'b1;
                        rsp_in = '{address: '0, status: STAT_NO_FIT};
                     end else begin
                        cur_in   = head_ff[SLOT_W-1:0];
                        steps_in = '0;
                        op_in    = OP_WALK;
                     end
                  end
               end else begin
                  if (!ready_ff || req_data.block_address < ADDR_W'(HEADER_BYTES)
                      || off[ALIGN_SH-1:0] != '0) begin
                     finish = 1'b1;
                     rsp_in = '{address: '0, status: STAT_OK};
                  end else begin
                     blk_in = off[ADDR_W-1:ALIGN_SH];
                     op_in  = OP_F_HDR;
                  end
               end
            end
         end
         S_INIT0: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = '0;
            mem_req.wdata = '{size: INIT_SIZE, free: 1'b1, psize: '0, pfree: 1'b0,
                              nxt: NIL_LINK, prv: NIL_LINK};
         end
         S_INIT1: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = slot_after('0, INIT_SIZE);
            mem_req.wdata = '{size: '0, free: 1'b0, psize: INIT_SIZE, pfree: 1'b1,
                              nxt: NIL_LINK, prv: NIL_LINK};
            head_in  = '0;
            ready_in = 1'b1;
            cur_in   = '0;
            steps_in = '0;
            op_in    = OP_WALK;
         end
         S_RD: begin
            mem_req.re    = 1'b1;
            mem_req.raddr = op_addr;
         end
         S_WR: begin
            if (op_writes) begin
               mem_req.we    = 1'b1;
               mem_req.waddr = op_addr;
               mem_req.wdata = patched;
               sz_in         = patched.size;
            end
            case (op_ff)
               OP_WALK: begin
                  if ({1'b0, rd_data.size} >= need_ff) begin
                     cw_size_in = rd_data.size;
                     cw_free_in = rd_data.free;
                     cont_in    = C_ALLOC;
                     ul_start   = 1'b1;
                     ul_s       = cur_ff;
                     ul_n       = nx;
                     ul_p       = link_of(rd_data.prv);
                  end else if (nx == NIL_LINK || (steps_ff + 1'b1) == LINK_W'(SLOTS)) begin
                     finish = 1'b1;
                     rsp_in = '{address: '0, status: STAT_NO_FIT};
                  end else begin
                     cur_in        = nx[SLOT_W-1:0];
                     steps_in      = steps_ff + 1'b1;
                     walk_more     = 1'b1;
                     mem_req.re    = 1'b1;
                     mem_req.raddr = nx[SLOT_W-1:0];
                  end
               end
               OP_UL_HEAD, OP_UL_N: op_in = OP_UL_SELF;
               OP_UL_P:  op_in = (ul_nxt_ff != NIL_LINK) ? OP_UL_N : OP_UL_SELF;
               OP_UL_SELF: begin
                  case (cont_ff)
                     C_ALLOC: begin
                        if ({2'b0, cw_size_ff} >
                            ({1'b0, need_ff} + (NEED_W + 1)'(MIN_PAYLOAD + HEADER_BYTES))) begin
                           op_in = OP_A_SIZE;
                        end else begin
                           got_in = cur_ff;
                           op_in  = OP_A_FREE;
                        end
                     end
                     C_FREE_B: begin
                        blk_in = b_ff;
                        op_in  = OP_F_SIZE;
                     end
                     default: op_in = OP_F_ADD;
                  endcase
               end
               OP_A_SIZE: begin
                  got_in = slot_after(cur_ff, patched.size);
                  op_in  = OP_A_GOT;
               end
               OP_A_GOT: begin
                  pu_in = cur_ff;
                  op_in = OP_PUSH;
               end
               OP_A_FREE: begin
                  a_in  = slot_after(got_ff, patched.size);
                  op_in = OP_A_TAIL;
               end
               OP_A_TAIL: begin
                  finish = 1'b1;
                  rsp_in = '{address: (ADDR_W'(got_ff) << ALIGN_SH) + ADDR_W'(HEADER_BYTES),
                             status: STAT_OK};
               end
               OP_PUSH: begin
                  if (head_ff == NIL_LINK) begin
                     head_in   = {1'b0, pu_ff};
                     push_done = 1'b1;
                  end else begin
                     op_in = OP_PUSH_HD;
                  end
               end
               OP_PUSH_HD: begin
                  head_in   = {1'b0, pu_ff};
                  push_done = 1'b1;
               end
               OP_F_HDR: begin
                  if (rd_data.free) begin
                     finish = 1'b1;
                     rsp_in = '{address: '0, status: STAT_OK};
                  end else begin
                     a_in = slot_after(blk_ff, rd_data.size);
                     b_in = slot_before(blk_ff, rd_data.psize);
                     if (rd_data.pfree) begin
                        ns_in = rd_data.size + SIZE_W'(HEADER_BYTES) + rd_data.psize;
                        op_in = OP_F_RDB;
                     end else begin
                        op_in = OP_F_RDA;
                     end
                  end
               end
               OP_F_RDB: begin
                  cont_in  = C_FREE_B;
                  ul_start = 1'b1;
                  ul_s     = b_ff;
                  ul_n     = nx;
                  ul_p     = link_of(rd_data.prv);
               end
               OP_F_SIZE: op_in = OP_F_RDA;
               OP_F_RDA: begin
                  if (rd_data.free) begin
                     asz_in   = rd_data.size;
                     cont_in  = C_FREE_A;
                     ul_start = 1'b1;
                     ul_s     = a_ff;
                     ul_n     = nx;
                     ul_p     = link_of(rd_data.prv);
                  end else begin
                     op_in = OP_F_FREE;
                  end
               end
               OP_F_ADD: op_in = OP_F_FREE;
               OP_F_FREE: begin
                  a_in  = slot_after(blk_ff, patched.size);
                  op_in = OP_F_TAIL;
               end
               OP_F_TAIL: begin
                  pu_in = blk_ff;
                  op_in = OP_PUSH;
               end
               default: op_in = op_ff;
            endcase
         end
         default: finish = 1'b0;
      endcase

      if (ul_start) begin
         ul_slot_in = ul_s;
         ul_nxt_in  = ul_n;
         ul_prv_in  = ul_p;
         op_in      = ul_first(ul_s, ul_n, ul_p, head_ff);
         if ({1'b0, ul_s} == head_ff) begin
            head_in = ul_n;
         end
      end

      if (push_done) begin
         if (mode_ff == MODE_ALLOC) begin
            op_in = OP_A_FREE;
         end else begin
            finish = 1'b1;
            rsp_in = '{address: '0, status: STAT_OK};
         end
      end

      if (finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ready_ff     <= 1'b0;
         head_ff      <= NIL_LINK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ready_ff     <= ready_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      cont_ff    <= cont_in;
      mode_ff    <= mode_in;
      need_ff    <= need_in;
      cur_ff     <= cur_in;
      got_ff     <= got_in;
      blk_ff     <= blk_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      pu_ff      <= pu_in;
      ns_ff      <= ns_in;
      asz_ff     <= asz_in;
      sz_ff      <= sz_in;
      cw_size_ff <= cw_size_in;
      cw_free_ff <= cw_free_in;
      ul_slot_ff <= ul_slot_in;
      ul_nxt_ff  <= ul_nxt_in;
      ul_prv_ff  <= ul_prv_in;
      steps_ff   <= steps_in;
      rsp_ff     <= rsp_in;
   end

endmodule

// ===== design/first_fit_heap_allocator.sv =====
// Top level of the boundary-tag first-fit heap allocator.
// Depends on hfa_pkg, hfa_hdr_mem and hfa_ctrl.
//
//   channel | ports                      | transfer
//   request | start, busy, req_data      | start high while busy low
//   result  | rsp_valid, rsp_data        | one cycle with rsp_valid high
//
// A zero-size allocate, a rejected free and an allocate on an empty list answer
// in the cycle after acceptance. A walk visits one free-list entry per cycle over
// the header memory read port; every header update is a read-modify-write over
// S_RD and S_WR. An allocate visits k entries and makes 3 to 9 updates (none
// with no fit); freeing a block already marked free stops after one header read.
// The first nonzero allocate first sets up the arena in S_INIT0 and S_INIT1; k is
// bounded by one pass over all slots. Reset is synchronous and clears only control
// state; no clearing pass runs. The receiver cannot stall.
module first_fit_heap_allocator import hfa_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_data,
   output logic    busy,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   mem_req_type  mem_req;
   hdr_word_type rd_data;

   hfa_hdr_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   hfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .mem_req   (mem_req),
      .rd_data   (rd_data)
   );

`ifndef SYNTH
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while a transaction is still in progress");

   a_zero_size: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.mode == MODE_ALLOC && req_data.request_bytes == '0)
      |=> (rsp_valid && rsp_data.status == STAT_BAD_SIZE))
      else $error("zero-size allocate not rejected at once");

   a_fail_null: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != STAT_OK) |-> rsp_data.address == '0)
      else $error("failed transaction carries an address");

   a_free_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.mode == MODE_FREE)
      |=> (busy || (rsp_valid && rsp_data.address == '0 && rsp_data.status == STAT_OK)))
      else $error("free transaction neither in progress nor answered");
`endif

endmodule
